FILE: hdl/register_bytecode_executor_assert.svh
// Assertion macros for the executor modules; rbe_back is the one that includes them.
`ifndef REGISTER_BYTECODE_EXECUTOR_ASSERT_SVH
`define REGISTER_BYTECODE_EXECUTOR_ASSERT_SVH

// Same-cycle implication, checked once reset is released.
`define RBE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked once reset is released.
`define RBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rbe_pkg.sv
package rbe_pkg;

    localparam int NUM_VARS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DATA_W          = 32;
    localparam int IDX_W           = 8;

    typedef enum logic [2:0] {
        OP_LDC = 3'd0,
        OP_LDV = 3'd1,
        OP_STV = 3'd2,
        OP_ADD = 3'd3,
        OP_SUB = 3'd4,
        OP_MUL = 3'd5,
        OP_DIV = 3'd6,
        OP_BAD = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BADOP = 2'd1,
        ST_DIVZ  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_op               op;
        t_status           status;
        logic [DATA_W-1:0] operand_a;
        logic [IDX_W-1:0]  operand_b;
        logic [IDX_W-1:0]  dest;
        logic              last;
    } t_qentry;

endpackage

FILE: hdl/rbe_ram.sv
module rbe_ram #(
    parameter int WIDTH = rbe_pkg::DATA_W,
    parameter int DEPTH = rbe_pkg::NUM_VARS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: hdl/rbe_fifo.sv
module rbe_fifo #(
    parameter int WIDTH = $bits(rbe_pkg::t_qentry),
    parameter int DEPTH = rbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hdl/rbe_front.sv
module rbe_front #(
    parameter int NUM_VARS = rbe_pkg::NUM_VARS_DEF
) (
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_req_type,
    input  logic signed [31:0]        i_first_operand,
    input  logic [7:0]                i_second_operand,
    input  logic [7:0]                i_dest_index,
    input  logic                      i_is_last,
    input  logic                      i_full,
    output logic                      o_push,
    output rbe_pkg::t_qentry          o_entry
);

    localparam logic [8:0] NV = 9'(NUM_VARS);

    rbe_pkg::t_op     op;
    rbe_pkg::t_status st;
    logic             a_ok;
    logic             b_ok;
    logic             d_ok;

    assign op   = rbe_pkg::t_op'(i_req_type);
    assign a_ok = (i_first_operand[31:8] == '0) && ({1'b0, i_first_operand[7:0]} < NV);
    assign b_ok = ({1'b0, i_second_operand} < NV);
    assign d_ok = ({1'b0, i_dest_index} < NV);

    always_comb begin
        st = rbe_pkg::ST_OK;
        unique case (op)
            rbe_pkg::OP_LDC: begin
                if (!d_ok) st = rbe_pkg::ST_RANGE;
            end
            rbe_pkg::OP_LDV, rbe_pkg::OP_STV: begin
                if (!a_ok || !d_ok) st = rbe_pkg::ST_RANGE;
            end
            rbe_pkg::OP_ADD, rbe_pkg::OP_SUB, rbe_pkg::OP_MUL, rbe_pkg::OP_DIV: begin
                if (!a_ok || !b_ok || !d_ok) st = rbe_pkg::ST_RANGE;
            end
            rbe_pkg::OP_BAD: begin
                st = rbe_pkg::ST_BADOP;
            end
            default: begin
                st = rbe_pkg::ST_BADOP;
            end
        endcase
    end

    assign o_in_ready        = !i_full;
    assign o_push            = i_in_valid && !i_full;
    assign o_entry.op        = op;
    assign o_entry.status    = st;
    assign o_entry.operand_a = $unsigned(i_first_operand);
    assign o_entry.operand_b = i_second_operand;
    assign o_entry.dest      = i_dest_index;
    assign o_entry.last      = i_is_last;

endmodule

FILE: hdl/rbe_div.sv
module rbe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [32:0] trial;
    logic        fits;
    logic        na;
    logic        nb;

    assign na    = i_dividend[31];
    assign nb    = i_divisor[31];
    assign trial = {r_rem, r_quo[31]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= na ? 32'd0 - i_dividend : i_dividend;
            r_dvs <= nb ? 32'd0 - i_divisor : i_divisor;
            r_neg <= na ^ nb;
        end else if (r_busy) begin
            r_rem <= fits ? 32'(trial - {1'b0, r_dvs}) : trial[31:0];
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_neg ? 32'd0 - r_quo : r_quo;

endmodule

FILE: hdl/rbe_back.sv
`include "register_bytecode_executor_assert.svh"

module rbe_back #(
    parameter int NUM_VARS = rbe_pkg::NUM_VARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  rbe_pkg::t_qentry   i_q_entry,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_value,
    output logic [7:0]         o_index,
    output rbe_pkg::t_status   o_status,
    output logic               o_last
);

    localparam int AW = $clog2(NUM_VARS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DIV   = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    rbe_pkg::t_qentry   r_cur;
    logic [31:0]        r_val;
    rbe_pkg::t_status   r_st;
    logic [NUM_VARS-1:0] r_vld;
    logic               r_vld_a;
    logic               r_vld_b;
    logic               r_out_vld;
    logic [31:0]        r_out_value;
    logic [7:0]         r_out_index;
    rbe_pkg::t_status   r_out_status;
    logic               r_out_last;

    logic               q_pop;
    logic               rd_en;
    logic               we;
    logic               out_free;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        rd_a;
    logic [31:0]        rd_b;
    logic [31:0]        x;
    logic [31:0]        y;
    logic [31:0]        exec_val;
    rbe_pkg::t_status   exec_st;
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [31:0]        quotient;

    assign rd_addr_a = i_q_entry.operand_a[AW-1:0];
    assign rd_addr_b = i_q_entry.operand_b[AW-1:0];
    assign wr_addr   = r_cur.dest[AW-1:0];
    assign x         = r_vld_a ? rd_a : '0;
    assign y         = r_vld_b ? rd_b : '0;
    assign out_free  = !r_out_vld || i_out_ready;

    rbe_ram #(
        .WIDTH(32),
        .DEPTH(NUM_VARS)
    ) u_vars (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (wr_addr),
        .i_wdata  (r_val),
        .i_re     (rd_en),
        .i_raddr_a(rd_addr_a),
        .i_raddr_b(rd_addr_b),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    rbe_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(x),
        .i_divisor (y),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quotient(quotient)
    );

    always_comb begin
        exec_val = '0;
        exec_st  = r_cur.status;
        if (r_cur.status == rbe_pkg::ST_OK) begin
            unique case (r_cur.op)
                rbe_pkg::OP_LDC:                  exec_val = r_cur.operand_a;
                rbe_pkg::OP_LDV, rbe_pkg::OP_STV: exec_val = x;
                rbe_pkg::OP_ADD:                  exec_val = x + y;
                rbe_pkg::OP_SUB:                  exec_val = x - y;
                rbe_pkg::OP_MUL:                  exec_val = x * y;
                rbe_pkg::OP_DIV: begin
                    if (y == '0) exec_st = rbe_pkg::ST_DIVZ;
                end
                rbe_pkg::OP_BAD:                  exec_st = rbe_pkg::ST_BADOP;
                default:                          exec_st = rbe_pkg::ST_BADOP;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        q_pop     = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        we        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    q_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_cur.op == rbe_pkg::OP_DIV && exec_st == rbe_pkg::ST_OK) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    we      = (r_st == rbe_pkg::ST_OK);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_state <= n_state;
            if (we) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (r_state == S_WRITE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_cur   <= i_q_entry;
            r_vld_a <= r_vld[rd_addr_a];
            r_vld_b <= r_vld[rd_addr_b];
        end
        if (r_state == S_READ) begin
            r_val <= exec_val;
            r_st  <= exec_st;
        end else if (r_state == S_DIV && div_done) begin
            r_val <= quotient;
        end
        if (r_state == S_WRITE && out_free) begin
            r_out_value  <= r_val;
            r_out_index  <= r_cur.dest;
            r_out_status <= r_st;
            r_out_last   <= r_cur.last;
        end
    end

    assign o_q_pop     = q_pop;
    assign o_out_valid = r_out_vld;
    assign o_value     = r_out_value;
    assign o_index     = r_out_index;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    `RBE_ASSERT_IMPL(a_div_nonzero, div_start, y != '0 && r_cur.status == rbe_pkg::ST_OK, "divide started on a zero or faulted operand")
    `RBE_ASSERT_IMPL(a_write_ok, we, r_st == rbe_pkg::ST_OK && r_state == S_WRITE, "variable written on a faulted instruction")
    `RBE_ASSERT_NEXT(a_pop_reads, q_pop, r_state == S_READ, "popped entry not followed by a read")
    `RBE_ASSERT_IMPL(a_div_runs, r_state == S_DIV && !div_done, div_busy, "waiting on an idle divider")
    `RBE_ASSERT_NEXT(a_out_loaded, r_state == S_WRITE && out_free, r_out_vld, "result dropped at output register")

endmodule

FILE: hdl/register_bytecode_executor.sv
// Register bytecode executor: one three-address instruction per input transfer.
// Input channel i_in_valid/o_in_ready carries req_type, first_operand,
// second_operand, dest_index and is_last; every instruction gives exactly one
// result on o_out_valid/i_out_ready with written_value, written_index, status
// and last_of_program, in instruction order.
// A front end classifies opcode and index range and pushes into a queue of
// QUEUE_DEPTH entries; a back end reads the variable file, executes and writes.
// Each instruction is queued, then passes the back end's read, execute and
// write sequence, with divide using the 32-step bit-per-cycle divider; the
// back end takes no new instruction until the current result is written.
// Reset clears the variable file (per-entry valid bits), the queue and the
// output register. When the receiver stalls, the result holds in the output
// register, the back end waits with the next result, and the queue keeps
// taking instructions until it is full.
module register_bytecode_executor #(
    parameter int NUM_VARS    = rbe_pkg::NUM_VARS_DEF,
    parameter int QUEUE_DEPTH = rbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_first_operand,
    input  logic [7:0]         i_second_operand,
    input  logic [7:0]         i_dest_index,
    input  logic               i_is_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_written_value,
    output logic [7:0]         o_written_index,
    output logic [1:0]         o_status,
    output logic               o_last_of_program
);

    localparam int QW = $bits(rbe_pkg::t_qentry);

    rbe_pkg::t_qentry front_entry;
    rbe_pkg::t_qentry back_entry;
    rbe_pkg::t_status back_status;
    logic [QW-1:0]    q_wdata;
    logic [QW-1:0]    q_rdata;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [31:0]      back_value;

    rbe_front #(
        .NUM_VARS(NUM_VARS)
    ) u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_first_operand (i_first_operand),
        .i_second_operand(i_second_operand),
        .i_dest_index    (i_dest_index),
        .i_is_last       (i_is_last),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_entry         (front_entry)
    );

    assign q_wdata    = front_entry;
    assign back_entry = rbe_pkg::t_qentry'(q_rdata);

    rbe_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .i_pop  (q_pop),
        .o_data (q_rdata),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    rbe_back #(
        .NUM_VARS(NUM_VARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_entry  (back_entry),
        .o_q_pop    (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_value    (back_value),
        .o_index    (o_written_index),
        .o_status   (back_status),
        .o_last     (o_last_of_program)
    );

    assign o_written_value = $signed(back_value);
    assign o_status        = back_status;

endmodule
